>>> src/gte_pkg.sv
`default_nettype none
package gte_pkg;

   // Field and register widths.
   localparam int ANGLE_W = 32;
   localparam int LENGTH_W = 40;
   localparam int STATUS_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [LENGTH_W-1:0] length_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_SEMI_MAJOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FLATTENING = 2'd1;

   localparam logic [CSR_DATA_W-1:0] SEMI_MAJOR_RESET = 32'd1632803072;
   localparam logic [CSR_DATA_W-1:0] FLATTENING_RESET = 32'd14400212;

   // Status codes.
   localparam status_type STATUS_OK = 2'd0;
   localparam status_type STATUS_LAT_RANGE = 2'd1;
   localparam status_type STATUS_LON_RANGE = 2'd2;

   // Angle limits in Q3.29.
   localparam logic [31:0] HALF_PI_Q29 = 32'd843314856;
   localparam logic [31:0] PI_Q29 = 32'd1686629713;

   // Series datapath widths.
   localparam int TERMS = 10;
   localparam int CHAINS = 4;
   localparam int U_W = 30;
   localparam int T_W = 34;
   localparam int ACC_W = 36;
   localparam int DIV_W = 9;
   localparam int TRIG_W = 31;
   localparam int RECIP_SHIFT = 34;

   // Root and quotient widths.
   localparam int ROOT_W = 63;
   localparam int DEN_W = 32;
   localparam int QUO_W = 51;
   localparam int N_W = 50;
   localparam int N_SHIFT = 31;
   localparam logic [N_W-1:0] N_CAP = {N_W{1'b1}};

   // Per-term divisors k(k+1) and their floor reciprocals scaled by 2^34.
   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
   localparam logic [DIV_W-1:0] SIN_DIV [TERMS] = '{
      9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420};
   localparam logic [DIV_W-1:0] COS_DIV [TERMS] = '{
      9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380};
   localparam logic [T_W-1:0] SIN_RECIP [TERMS] = '{
      34'(RECIP_ONE / 64'd6), 34'(RECIP_ONE / 64'd20), 34'(RECIP_ONE / 64'd42),
      34'(RECIP_ONE / 64'd72), 34'(RECIP_ONE / 64'd110), 34'(RECIP_ONE / 64'd156),
      34'(RECIP_ONE / 64'd210), 34'(RECIP_ONE / 64'd272), 34'(RECIP_ONE / 64'd342),
      34'(RECIP_ONE / 64'd420)};
   localparam logic [T_W-1:0] COS_RECIP [TERMS] = '{
      34'(RECIP_ONE / 64'd2), 34'(RECIP_ONE / 64'd12), 34'(RECIP_ONE / 64'd30),
      34'(RECIP_ONE / 64'd56), 34'(RECIP_ONE / 64'd90), 34'(RECIP_ONE / 64'd132),
      34'(RECIP_ONE / 64'd182), 34'(RECIP_ONE / 64'd240), 34'(RECIP_ONE / 64'd306),
      34'(RECIP_ONE / 64'd380)};

   // Pipeline stage positions.
   localparam int ST_P0 = 0;
   localparam int ST_P1 = 1;
   localparam int ST_SER0 = 2;
   localparam int ST_F = ST_SER0 + 3 * TERMS;
   localparam int ST_S1 = ST_F + 1;
   localparam int ST_S2 = ST_S1 + 1;
   localparam int ST_ROOT0 = ST_S2 + 1;
   localparam int ST_D0 = ST_ROOT0 + (ROOT_W + 1) / 2;
   localparam int ST_DIV0 = ST_D0 + 1;
   localparam int ST_NC = ST_DIV0 + QUO_W;
   localparam int ST_T1 = ST_NC + 1;
   localparam int ST_T2 = ST_T1 + 1;
   localparam int ST_T3 = ST_T2 + 1;
   localparam int ST_T4 = ST_T3 + 1;
   localparam int ST_T5 = ST_T4 + 1;
   localparam int ST_T6 = ST_T5 + 1;
   localparam int ST_T7 = ST_T6 + 1;
   localparam int STAGES = ST_T7 + 1;

   // Data that rides along with an item through the pipeline.
   typedef struct packed {
      length_type altitude;
      logic lat_neg;
      logic lon_neg;
      logic co_neg;
      status_type status;
      logic ovf;
      logic [TRIG_W-1:0] sl;
      logic [TRIG_W-1:0] cl;
      logic [TRIG_W-1:0] so;
      logic [TRIG_W-1:0] co;
   } side_type;

endpackage
`default_nettype wire

>>> src/gte_req_if.sv
`default_nettype none
interface gte_req_if import gte_pkg::*; ();
   logic valid;
   logic ready;
   angle_type latitude;
   angle_type longitude;
   length_type altitude;

   modport source (output valid, output latitude, output longitude, output altitude,
                   input ready);
   modport sink (input valid, input latitude, input longitude, input altitude,
                 output ready);
endinterface
`default_nettype wire

>>> src/gte_rsp_if.sv
`default_nettype none
interface gte_rsp_if import gte_pkg::*; ();
   logic valid;
   logic ready;
   length_type ecef_x;
   length_type ecef_y;
   length_type ecef_z;
   status_type status;

   modport source (output valid, output ecef_x, output ecef_y, output ecef_z,
                   output status, input ready);
   modport sink (input valid, input ecef_x, input ecef_y, input ecef_z,
                 input status, output ready);
endinterface
`default_nettype wire

>>> src/gte_term_cell.sv
`default_nettype none
module gte_term_cell import gte_pkg::*; (
   input  logic                    clock,
   input  logic                    enable,
   input  logic                    sub,
   input  logic [DIV_W-1:0]        div,
   input  logic [T_W-1:0]          recip,
   input  logic [U_W-1:0]          in_u,
   input  logic [T_W-1:0]          in_t,
   input  logic signed [ACC_W-1:0] in_acc,
   output logic [U_W-1:0]          out_u,
   output logic [T_W-1:0]          out_t,
   output logic signed [ACC_W-1:0] out_acc
);

   logic [63:0] prod_a;
   logic [T_W-1:0] p_a_ff, p_a_in;
   logic [U_W-1:0] u_a_ff;
   logic signed [ACC_W-1:0] acc_a_ff;

   logic [T_W+RECIP_SHIFT-1:0] prod_b;
   logic [T_W-1:0] q_b_ff, q_b_in;
   logic [T_W-1:0] p_b_ff;
   logic [U_W-1:0] u_b_ff;
   logic signed [ACC_W-1:0] acc_b_ff;

   logic [T_W+DIV_W-1:0] prod_c, rem_c;
   logic [T_W-1:0] q_c;
   logic signed [ACC_W-1:0] q_ext;
   logic [U_W-1:0] u_c_ff;
   logic [T_W-1:0] t_c_ff;
   logic signed [ACC_W-1:0] acc_c_ff, acc_c_in;

   // Previous term times the angle, back to Q32.
   assign prod_a = 64'(in_t) * 64'(in_u);
   assign p_a_in = prod_a[T_W+28:29];

   // Quotient estimate by the reciprocal; low by at most one.
   assign prod_b = (T_W+RECIP_SHIFT)'(p_a_ff) * (T_W+RECIP_SHIFT)'(recip);
   assign q_b_in = prod_b[T_W+RECIP_SHIFT-1:RECIP_SHIFT];

   // Correct the estimate and add the term into the running sum.
   assign prod_c = (T_W+DIV_W)'(q_b_ff) * (T_W+DIV_W)'(div);
   assign rem_c = (T_W+DIV_W)'(p_b_ff) - prod_c;
   assign q_c = (rem_c >= (T_W+DIV_W)'(div)) ? q_b_ff + T_W'(1) : q_b_ff;
   assign q_ext = $signed({{(ACC_W-T_W){1'b0}}, q_c});
   assign acc_c_in = sub ? acc_b_ff - q_ext : acc_b_ff + q_ext;

   always_ff @(posedge clock) begin
      if (enable) begin
         p_a_ff <= p_a_in;
         u_a_ff <= in_u;
         acc_a_ff <= in_acc;
         q_b_ff <= q_b_in;
         p_b_ff <= p_a_ff;
         u_b_ff <= u_a_ff;
         acc_b_ff <= acc_a_ff;
         u_c_ff <= u_b_ff;
         t_c_ff <= q_c;
         acc_c_ff <= acc_c_in;
      end
   end

   assign out_u = u_c_ff;
   assign out_t = t_c_ff;
   assign out_acc = acc_c_ff;

endmodule
`default_nettype wire

>>> src/gte_root_cell.sv
`default_nettype none
module gte_root_cell import gte_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  logic [ROOT_W-1:0] bit_val,
   input  logic [ROOT_W-1:0] in_v,
   input  logic [ROOT_W-1:0] in_r,
   output logic [ROOT_W-1:0] out_v,
   output logic [ROOT_W-1:0] out_r
);

   logic [ROOT_W:0] trial;
   logic take;
   logic [ROOT_W-1:0] v_ff, v_in, r_ff, r_in;

   // One digit of the square root: try the trial subtrahend.
   assign trial = {1'b0, in_r} + {1'b0, bit_val};
   assign take = {1'b0, in_v} >= trial;
   assign v_in = take ? in_v - trial[ROOT_W-1:0] : in_v;
   assign r_in = take ? (in_r >> 1) + bit_val : in_r >> 1;

   always_ff @(posedge clock) begin
      if (enable) begin
         v_ff <= v_in;
         r_ff <= r_in;
      end
   end

   assign out_v = v_ff;
   assign out_r = r_ff;

endmodule
`default_nettype wire

>>> src/gte_div_cell.sv
`default_nettype none
module gte_div_cell import gte_pkg::*; (
   input  logic             clock,
   input  logic             enable,
   input  logic             num_bit,
   input  logic [DEN_W-1:0] in_den,
   input  logic [DEN_W-1:0] in_rem,
   input  logic [QUO_W-1:0] in_quo,
   output logic [DEN_W-1:0] out_den,
   output logic [DEN_W-1:0] out_rem,
   output logic [QUO_W-1:0] out_quo
);

   logic [DEN_W:0] trial;
   logic take;
   logic [DEN_W-1:0] den_ff, rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff;

   // One restoring step: bring down the next numerator bit.
   assign trial = {in_rem, num_bit};
   assign take = trial >= {1'b0, in_den};
   assign rem_in = take ? DEN_W'(trial - {1'b0, in_den}) : trial[DEN_W-1:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         den_ff <= in_den;
         rem_ff <= rem_in;
         quo_ff <= {in_quo[QUO_W-2:0], take};
      end
   end

   assign out_den = den_ff;
   assign out_rem = rem_ff;
   assign out_quo = quo_ff;

endmodule
`default_nettype wire

>>> src/geodetic_to_ecef.sv
`default_nettype none
// Geodetic (latitude, longitude, altitude) to ECEF x, y, z conversion. The block accepts
// one item every clock cycle while the pipeline is not held. The pipeline is built from the
// Taylor-series cells for sine and cosine (ten terms per row), the 32 square-root cells and
// the 51 long-division cells that form the prime vertical radius. When the result is not
// taken the whole pipeline holds, so the input stalls only while the output register is
// full and not being read. Configuration (semi-major axis and flattening) must be written
// only while no item is in flight.
module geodetic_to_ecef import gte_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   gte_req_if.sink                req,
   gte_rsp_if.source              rsp
);

   function automatic logic [TRIG_W-1:0] trig_finish(input logic signed [ACC_W-1:0] acc);
      logic [ACC_W:0] sum;
      logic [TRIG_W-1:0] lim;
      begin
         lim = TRIG_W'(1) << (TRIG_W - 1);
         sum = acc[ACC_W-1] ? '0 : {1'b0, acc[ACC_W-1:0]} + (ACC_W+1)'(2);
         trig_finish = ((sum >> 2) > (ACC_W+1)'(lim)) ? lim : TRIG_W'(sum >> 2);
      end
   endfunction

   function automatic logic [51:0] mul_join(input logic [50:0] hi, input logic [62:0] lo);
      mul_join = 52'({hi, 2'b00} + 53'(lo >> 30));
   endfunction

   function automatic length_type pack(input logic [51:0] mag, input logic neg);
      logic [51:0] lim;
      begin
         lim = 52'(1) << (LENGTH_W - 1);
         if (neg) begin
            pack = (mag >= lim) ? {1'b1, {(LENGTH_W-1){1'b0}}} : LENGTH_W'(~mag + 52'(1));
         end else begin
            pack = (mag >= lim) ? {1'b0, {(LENGTH_W-1){1'b1}}} : mag[LENGTH_W-1:0];
         end
      end
   endfunction

   logic advance;
   logic [STAGES-1:0] vld_ff;
   side_type side_ff [STAGES];
   side_type side_in [STAGES];
   side_type side0;

   logic [CSR_DATA_W-1:0] semi_ff, flat_ff;
   logic [63:0] ff_prod;
   logic [32:0] e2_ff, e2_in, w_ff;

   // Stage registers outside the cell rows.
   logic [31:0] alat, alon, fold;
   logic [31:0] p0_alat_ff, p0_alon_ff;
   logic [U_W-1:0] p1_u_ff [CHAINS];
   logic [T_W-1:0] p1_t_ff [CHAINS];
   logic signed [ACC_W-1:0] p1_acc_ff [CHAINS];
   logic p1_co_neg;
   logic [U_W-1:0] u_lat, u_lon;
   logic [61:0] s2_prod;
   logic [TRIG_W-1:0] s2_ff;
   logic [63:0] es_prod;
   logic [ROOT_W-1:0] d_ff;
   logic [DEN_W-1:0] root_out, rem0;
   logic [DEN_W-1:0] d0_rem_ff, d0_den_ff;
   logic [N_W-1:0] n_ff;
   logic [50:0] t1_phi_ff;
   logic [64:0] t1_plo_ff;
   logic signed [52:0] t1_rxy_ff, t3_rz_ff;
   logic [50:0] t2_nz_ff;
   logic [51:0] t2_mxy_ff, t4_mz_ff, t4_h_ff;
   logic t2_negxy_ff, t3_negxy_ff, t4_negxy_ff, t5_negxy_ff, t6_negxy_ff;
   logic t4_negz_ff, t5_negz_ff, t6_negz_ff;
   logic [50:0] t3_hh_ff, t5_xh_ff, t5_yh_ff, t5_zh_ff;
   logic [62:0] t3_hl_ff, t5_xl_ff, t5_yl_ff, t5_zl_ff;
   logic [51:0] t6_x_ff, t6_y_ff, t6_z_ff;
   length_type out_x_ff, out_y_ff, out_z_ff;

   // Cell row wiring.
   logic [U_W-1:0] ser_u [CHAINS][TERMS+1];
   logic [T_W-1:0] ser_t [CHAINS][TERMS+1];
   logic signed [ACC_W-1:0] ser_acc [CHAINS][TERMS+1];
   logic [ROOT_W-1:0] root_v [ROOT_W/2+2];
   logic [ROOT_W-1:0] root_r [ROOT_W/2+2];
   logic [DEN_W-1:0] div_den [QUO_W+1];
   logic [DEN_W-1:0] div_rem [QUO_W+1];
   logic [QUO_W-1:0] div_quo [QUO_W+1];

   // The pipeline moves whenever the output register can take an item.
   assign advance = !vld_ff[STAGES-1] || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], req.valid};
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         semi_ff <= SEMI_MAJOR_RESET;
         flat_ff <= FLATTENING_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SEMI_MAJOR: semi_ff <= csr_data;
            REG_FLATTENING: flat_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Squared eccentricity and its complement follow the flattening register.
   assign ff_prod = 64'(flat_ff) * 64'(flat_ff);
   assign e2_in = {flat_ff, 1'b0} - 33'(ff_prod[63:32]);

   always_ff @(posedge clock) begin
      e2_ff <= e2_in;
      w_ff <= (33'(1) << 32) - e2_ff;
   end

   // Input magnitudes and range checks.
   assign alat = req.latitude[ANGLE_W-1] ? ~req.latitude + 32'(1) : req.latitude;
   assign alon = req.longitude[ANGLE_W-1] ? ~req.longitude + 32'(1) : req.longitude;

   always_comb begin
      side0 = '0;
      side0.altitude = req.altitude;
      side0.lat_neg = req.latitude[ANGLE_W-1];
      side0.lon_neg = req.longitude[ANGLE_W-1];
      if (alat > HALF_PI_Q29) begin
         side0.status = STATUS_LAT_RANGE;
      end else if (alon > PI_Q29) begin
         side0.status = STATUS_LON_RANGE;
      end else begin
         side0.status = STATUS_OK;
      end
   end

   // Longitude beyond a right angle folds back and flips the cosine.
   assign p1_co_neg = p0_alon_ff > HALF_PI_Q29;
   assign fold = p1_co_neg ? PI_Q29 - p0_alon_ff : p0_alon_ff;
   assign u_lat = p0_alat_ff[U_W-1:0];
   assign u_lon = fold[U_W-1:0];

   // Side data shifts along; trig values and the overflow flag join on the way.
   always_comb begin
      side_in[ST_P0] = side0;
      for (int i = 1; i < STAGES; i++) begin
         side_in[i] = side_ff[i-1];
      end
      side_in[ST_P1].co_neg = p1_co_neg;
      side_in[ST_F].sl = trig_finish(ser_acc[0][TERMS]);
      side_in[ST_F].cl = trig_finish(ser_acc[1][TERMS]);
      side_in[ST_F].so = trig_finish(ser_acc[2][TERMS]);
      side_in[ST_F].co = trig_finish(ser_acc[3][TERMS]);
      side_in[ST_D0].ovf = rem0 >= root_out;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < STAGES; i++) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   // Head of the series rows: first term and starting sum.
   always_ff @(posedge clock) begin
      if (advance) begin
         p0_alat_ff <= alat;
         p0_alon_ff <= alon;
         for (int ch = 0; ch < CHAINS; ch++) begin
            p1_u_ff[ch] <= (ch < 2) ? u_lat : u_lon;
            if ((ch % 2) == 0) begin
               p1_t_ff[ch] <= T_W'({((ch < 2) ? u_lat : u_lon), 3'b000});
               p1_acc_ff[ch] <= $signed(ACC_W'({((ch < 2) ? u_lat : u_lon), 3'b000}));
            end else begin
               p1_t_ff[ch] <= T_W'(1) << 32;
               p1_acc_ff[ch] <= ACC_W'(1) << 32;
            end
         end
      end
   end

   // Series rows: latitude sine, latitude cosine, longitude sine, longitude cosine.
   for (genvar ch = 0; ch < CHAINS; ch++) begin : g_chain
      assign ser_u[ch][0] = p1_u_ff[ch];
      assign ser_t[ch][0] = p1_t_ff[ch];
      assign ser_acc[ch][0] = p1_acc_ff[ch];
      for (genvar c = 0; c < TERMS; c++) begin : g_term
         gte_term_cell u_cell (
            .clock   (clock),
            .enable  (advance),
            .sub     (1'((c % 2) == 0)),
            .div     ((ch % 2) == 0 ? SIN_DIV[c] : COS_DIV[c]),
            .recip   ((ch % 2) == 0 ? SIN_RECIP[c] : COS_RECIP[c]),
            .in_u    (ser_u[ch][c]),
            .in_t    (ser_t[ch][c]),
            .in_acc  (ser_acc[ch][c]),
            .out_u   (ser_u[ch][c+1]),
            .out_t   (ser_t[ch][c+1]),
            .out_acc (ser_acc[ch][c+1])
         );
      end
   end

   // Radicand 1 - e2 sin^2 lat in Q62.
   assign s2_prod = 62'(side_ff[ST_F].sl) * 62'(side_ff[ST_F].sl);
   assign es_prod = 64'(e2_ff) * 64'(s2_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff <= s2_prod[TRIG_W+29:30];
         d_ff <= ROOT_W'((64'd1 << 62) - es_prod);
      end
   end

   // Square-root row, two radicand bits per cell.
   assign root_v[0] = d_ff;
   assign root_r[0] = '0;
   for (genvar i = 0; i < (ROOT_W + 1) / 2; i++) begin : g_root
      gte_root_cell u_cell (
         .clock   (clock),
         .enable  (advance),
         .bit_val (ROOT_W'(1) << (ROOT_W - 1 - 2 * i)),
         .in_v    (root_v[i]),
         .in_r    (root_r[i]),
         .out_v   (root_v[i+1]),
         .out_r   (root_r[i+1])
      );
   end

   // Divider setup: the top bits of a * 2^31 seed the remainder.
   assign root_out = root_r[(ROOT_W + 1) / 2][DEN_W-1:0];
   assign rem0 = DEN_W'(semi_ff >> (QUO_W - N_SHIFT));

   always_ff @(posedge clock) begin
      if (advance) begin
         d0_rem_ff <= rem0;
         d0_den_ff <= root_out;
      end
   end

   // Long-division row, one quotient bit per cell.
   assign div_den[0] = d0_den_ff;
   assign div_rem[0] = d0_rem_ff;
   assign div_quo[0] = '0;
   for (genvar c = 0; c < QUO_W; c++) begin : g_div
      localparam int J = QUO_W - 1 - c;
      logic nb;
      if (J >= N_SHIFT) begin : g_abit
         assign nb = semi_ff[J-N_SHIFT];
      end else begin : g_zbit
         assign nb = 1'b0;
      end
      gte_div_cell u_cell (
         .clock   (clock),
         .enable  (advance),
         .num_bit (nb),
         .in_den  (div_den[c]),
         .in_rem  (div_rem[c]),
         .in_quo  (div_quo[c]),
         .out_den (div_den[c+1]),
         .out_rem (div_rem[c+1]),
         .out_quo (div_quo[c+1])
      );
   end

   // Radius products, sign handling and saturation.
   always_ff @(posedge clock) begin
      if (advance) begin
         // Cap the radius on overflow or a zero root.
         n_ff <= (side_ff[ST_NC-1].ovf || div_quo[QUO_W][QUO_W-1]) ?
                 N_CAP : div_quo[QUO_W][N_W-1:0];
         // (1 - e2) N partials and N + h.
         t1_phi_ff <= 51'(n_ff[N_W-1:32]) * 51'(w_ff);
         t1_plo_ff <= 65'(n_ff[31:0]) * 65'(w_ff);
         t1_rxy_ff <= $signed({3'b000, n_ff}) + 53'(side_ff[ST_NC].altitude);
         t2_nz_ff <= 51'(t1_phi_ff + 51'(t1_plo_ff >> 32));
         t2_mxy_ff <= t1_rxy_ff[52] ? 52'(-t1_rxy_ff) : 52'(t1_rxy_ff);
         t2_negxy_ff <= t1_rxy_ff[52];
         t3_rz_ff <= $signed({2'b00, t2_nz_ff}) + 53'(side_ff[ST_T2].altitude);
         t3_hh_ff <= 51'(t2_mxy_ff[51:32]) * 51'(side_ff[ST_T2].cl);
         t3_hl_ff <= 63'(t2_mxy_ff[31:0]) * 63'(side_ff[ST_T2].cl);
         t3_negxy_ff <= t2_negxy_ff;
         t4_mz_ff <= t3_rz_ff[52] ? 52'(-t3_rz_ff) : 52'(t3_rz_ff);
         t4_negz_ff <= t3_rz_ff[52];
         t4_h_ff <= mul_join(t3_hh_ff, t3_hl_ff);
         t4_negxy_ff <= t3_negxy_ff;
         // Final products with the trig magnitudes.
         t5_xh_ff <= 51'(t4_h_ff[51:32]) * 51'(side_ff[ST_T4].co);
         t5_xl_ff <= 63'(t4_h_ff[31:0]) * 63'(side_ff[ST_T4].co);
         t5_yh_ff <= 51'(t4_h_ff[51:32]) * 51'(side_ff[ST_T4].so);
         t5_yl_ff <= 63'(t4_h_ff[31:0]) * 63'(side_ff[ST_T4].so);
         t5_zh_ff <= 51'(t4_mz_ff[51:32]) * 51'(side_ff[ST_T4].sl);
         t5_zl_ff <= 63'(t4_mz_ff[31:0]) * 63'(side_ff[ST_T4].sl);
         t5_negxy_ff <= t4_negxy_ff;
         t5_negz_ff <= t4_negz_ff;
         t6_x_ff <= mul_join(t5_xh_ff, t5_xl_ff);
         t6_y_ff <= mul_join(t5_yh_ff, t5_yl_ff);
         t6_z_ff <= mul_join(t5_zh_ff, t5_zl_ff);
         t6_negxy_ff <= t5_negxy_ff;
         t6_negz_ff <= t5_negz_ff;
         // Output register; an out-of-range angle gives zero coordinates.
         if (side_ff[ST_T6].status != STATUS_OK) begin
            out_x_ff <= '0;
            out_y_ff <= '0;
            out_z_ff <= '0;
         end else begin
            out_x_ff <= pack(t6_x_ff, t6_negxy_ff != side_ff[ST_T6].co_neg);
            out_y_ff <= pack(t6_y_ff, t6_negxy_ff != side_ff[ST_T6].lon_neg);
            out_z_ff <= pack(t6_z_ff, t6_negz_ff != side_ff[ST_T6].lat_neg);
         end
      end
   end

   assign rsp.valid = vld_ff[STAGES-1];
   assign rsp.ecef_x = out_x_ff;
   assign rsp.ecef_y = out_y_ff;
   assign rsp.ecef_z = out_z_ff;
   assign rsp.status = side_ff[ST_T7].status;

`ifndef SYNTHESIS
   // A held pipeline keeps every item where it is.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

   // An out-of-range angle must come out with zero coordinates.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != STATUS_OK) |->
      (rsp.ecef_x == '0 && rsp.ecef_y == '0 && rsp.ecef_z == '0))
      else $error("nonzero coordinates with error status");

   // Only the three defined status codes leave the block.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.status == STATUS_OK || rsp.status == STATUS_LAT_RANGE ||
                     rsp.status == STATUS_LON_RANGE))
      else $error("undefined status code");
`endif

endmodule
`default_nettype wire
